// ===== sv/emg_peak_toggle_detector_top_macros.svh =====
// assertion macros used by the checker file of the peak toggle detector
`ifndef EMG_PEAK_TOGGLE_DETECTOR_TOP_MACROS_SVH
`define EMG_PEAK_TOGGLE_DETECTOR_TOP_MACROS_SVH

// overlapping implication, disabled while reset is asserted
`define EMGPTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define EMGPTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/emgptd_pkg.sv =====
// shared types, codes and defaults of the peak toggle detector
package emgptd_pkg;

	localparam int SAMPLE_W = 11;
	localparam int CMD_W    = 3;
	localparam int GRIP_W   = 2;
	localparam int COUNT_W  = 8;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam int PEAK_WINDOW_DEFAULT = 25;
	localparam int HOLD_LENGTH_DEFAULT = 3;

	// hand command codes
	localparam logic [CMD_W-1:0] CMD_CLOSE     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_OPEN      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ERROR     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ALTERNATE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NEUTRAL   = 3'd4;

	// grip position codes
	localparam logic [GRIP_W-1:0] GRIP_CLOSE     = 2'd0;
	localparam logic [GRIP_W-1:0] GRIP_OPEN      = 2'd1;
	localparam logic [GRIP_W-1:0] GRIP_ALTERNATE = 2'd3;

	// register indexes
	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_THR_FIRST = 2'd1;
	localparam logic [1:0] REG_THR_SECOND = 2'd2;
	localparam logic [1:0] REG_ERR_LIMIT = 2'd3;

	localparam logic [SAMPLE_W-1:0] THR_FIRST_RESET  = 11'd100;
	localparam logic [SAMPLE_W-1:0] THR_SECOND_RESET = 11'd100;
	localparam logic [SAMPLE_W-1:0] ERR_LIMIT_RESET  = 11'd300;

	typedef struct packed {
		logic                two_channel_mode;
		logic [SAMPLE_W-1:0] threshold_first;
		logic [SAMPLE_W-1:0] threshold_second;
		logic [SAMPLE_W-1:0] error_limit;
	} cfg_t;

endpackage

// ===== sv/emgptd_regs.sv =====
// apb register file holding the detector configuration
module emgptd_regs import emgptd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.two_channel_mode <= 1'b0;
			cfg_q.threshold_first  <= THR_FIRST_RESET;
			cfg_q.threshold_second <= THR_SECOND_RESET;
			cfg_q.error_limit      <= ERR_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:       cfg_q.two_channel_mode <= pwdata[0];
				REG_THR_FIRST:  cfg_q.threshold_first  <= pwdata[SAMPLE_W-1:0];
				REG_THR_SECOND: cfg_q.threshold_second <= pwdata[SAMPLE_W-1:0];
				REG_ERR_LIMIT:  cfg_q.error_limit      <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_MODE:       prdata = {{(PDATA_W-1){1'b0}}, cfg_q.two_channel_mode};
			REG_THR_FIRST:  prdata = {{(PDATA_W-SAMPLE_W){1'b0}}, cfg_q.threshold_first};
			REG_THR_SECOND: prdata = {{(PDATA_W-SAMPLE_W){1'b0}}, cfg_q.threshold_second};
			REG_ERR_LIMIT:  prdata = {{(PDATA_W-SAMPLE_W){1'b0}}, cfg_q.error_limit};
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== sv/emgptd_engine.sv =====
// peak search state and command decision for one sample pair
module emgptd_engine import emgptd_pkg::*; #(
	parameter int PEAK_WINDOW = PEAK_WINDOW_DEFAULT,
	parameter int HOLD_LENGTH = HOLD_LENGTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [SAMPLE_W-1:0] first_sample,
	input  logic [SAMPLE_W-1:0] second_sample,
	input  cfg_t                cfg,
	output logic [CMD_W-1:0]    cmd
);

	localparam logic [COUNT_W-1:0] WINDOW_INIT = COUNT_W'(PEAK_WINDOW);
	localparam logic [COUNT_W-1:0] HOLD_MIN    = COUNT_W'(HOLD_LENGTH);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

	logic [GRIP_W-1:0]  grip_q, grip_d;
	logic [COUNT_W-1:0] hold_q, hold_d;
	logic               peak_q, peak_d;
	logic [COUNT_W-1:0] window_q, window_d;

	always_comb begin
		grip_d   = grip_q;
		hold_d   = hold_q;
		peak_d   = peak_q;
		window_d = window_q;
		cmd      = CMD_ERROR;
		if (first_sample <= cfg.error_limit) begin
			if (peak_q) begin
				// refractory countdown
				if (window_q <= COUNT_W'(1)) begin
					window_d = WINDOW_INIT;
					peak_d   = 1'b0;
				end else begin
					window_d = window_q - COUNT_W'(1);
				end
			end else begin
				if (first_sample >= cfg.threshold_first) begin
					hold_d = (hold_q == COUNT_MAX) ? hold_q : hold_q + COUNT_W'(1);
				end else begin
					hold_d = '0;
				end
				if (first_sample > cfg.threshold_first && hold_d >= HOLD_MIN) begin
					hold_d = '0;
					peak_d = 1'b1;
					grip_d = (grip_q == GRIP_OPEN) ? GRIP_CLOSE : GRIP_OPEN;
				end
			end
			cmd = {1'b0, grip_d};
			if (cfg.two_channel_mode) begin
				if (second_sample > cfg.error_limit) begin
					cmd = CMD_ERROR;
				end else if (!peak_d) begin
					if (grip_d == GRIP_ALTERNATE) begin
						cmd = CMD_NEUTRAL;
					end else if (second_sample > cfg.threshold_second) begin
						grip_d = GRIP_ALTERNATE;
						cmd    = CMD_ALTERNATE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grip_q   <= GRIP_OPEN;
			hold_q   <= '0;
			peak_q   <= 1'b0;
			window_q <= WINDOW_INIT;
		end else if (step) begin
			grip_q   <= grip_d;
			hold_q   <= hold_d;
			peak_q   <= peak_d;
			window_q <= window_d;
		end
	end

endmodule

// ===== sv/emg_peak_toggle_detector_top.sv =====
// top level of the emg peak toggle detector
// a sample pair is registered on transfer, its command is registered in the result stage when stage 1 advances
// throughput: one sample pair per cycle while the output is not stalled, the grip state decision is combinational
// reset: arst_n clears the pipeline valids, grip opens, counters and registers take defaults
// in_stall rises only while a finished command waits in the output register
module emg_peak_toggle_detector_top import emgptd_pkg::*; #(
	parameter int PEAK_WINDOW = PEAK_WINDOW_DEFAULT,
	parameter int HOLD_LENGTH = HOLD_LENGTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	// sample channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] first_sample,
	input  logic [SAMPLE_W-1:0] second_sample,
	// command channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CMD_W-1:0]    hand_command,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	cfg_t                cfg;

	// input register stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] first_s1;
	logic [SAMPLE_W-1:0] second_s1;

	// result register stage
	logic                valid_s2;
	logic [CMD_W-1:0]    cmd_s2;

	logic                advance;
	logic                in_take;
	logic [CMD_W-1:0]    cmd_next;

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	emgptd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// grip state only moves when the registered pair is handed to stage 2
	emgptd_engine #(
		.PEAK_WINDOW (PEAK_WINDOW),
		.HOLD_LENGTH (HOLD_LENGTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.first_sample  (first_s1),
		.second_sample (second_s1),
		.cfg           (cfg),
		.cmd           (cmd_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// sample payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			first_s1  <= first_sample;
			second_s1 <= second_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// command payload holds while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2 <= cmd_next;
		end
	end

	assign out_valid    = valid_s2;
	assign hand_command = cmd_s2;

endmodule

// ===== sv/emgptd_checker.sv =====
// port-level checks of the detector, bound to the top level
`include "emg_peak_toggle_detector_top_macros.svh"

module emgptd_checker import emgptd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [CMD_W-1:0]    hand_command
);

	// a held command transfer keeps its value
	`EMGPTD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(hand_command), "held command changed")

	// only defined commands leave the block
	`EMGPTD_ASSERT_IMPL(a_cmd_legal, clk, arst_n, out_valid, hand_command <= CMD_NEUTRAL, "undefined hand command")

	// the input side only backs up behind a blocked output
	`EMGPTD_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")

	// an accepted pair shows its command through the input and result registers when the output drains
	`EMGPTD_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 !out_stall, out_valid, "command missing after transfer")

endmodule

bind emg_peak_toggle_detector_top emgptd_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.hand_command (hand_command)
);
